>>> hw/rtl/hufdec_pkg.sv
package hufdec_pkg;

  // node table geometry
  localparam int unsigned MAX_NODES = 512;
  localparam int unsigned IDX_W     = $clog2(MAX_NODES);
  localparam int unsigned SYM_W     = 8;
  localparam int unsigned NBITS_W   = 4;
  localparam int unsigned BYTE_BITS = 8;

  // input tdata layout, lowest bit first
  localparam int unsigned IN_DATA_W = 48;
  localparam int unsigned CFG_ADDR_W = 3;

  // item kinds carried on in_tuser
  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_DECODE = 1'b1;

  // one node entry: left child, right child, leaf flag, symbol
  typedef struct packed {
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
    logic             leaf;
    logic [SYM_W-1:0] symbol;
  } node_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_WAIT_CUR,
    ST_CHECK,
    ST_FLUSH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;        // write one node entry
    logic start;       // latch a code byte
    logic rd_cur;      // read the entry at the walk position
    logic take_cur;    // capture that entry as current node
    logic rd_child;    // read the child chosen by the next bit
    logic step;        // retire one bit
    logic push_last;   // hand over the held symbol as last of run
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic bits_zero;
    logic cur_ok;
    logic pend_ok;
    logic out_free;
    logic is_leaf;
  } sts_t;

endpackage

>>> hw/rtl/hufdec_ctrl.sv
module hufdec_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_tuser,
  output logic                in_tready,
  input  hufdec_pkg::sts_t    sts,
  output hufdec_pkg::cmd_t    cmd
);

  hufdec_pkg::state_t state_r;
  hufdec_pkg::state_t state_nxt;
  logic               accept;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hufdec_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == hufdec_pkg::ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      hufdec_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_tuser == hufdec_pkg::FUNC_LOAD) begin
            cmd.load = 1'b1;
          end else begin
            cmd.start = 1'b1;
            state_nxt = hufdec_pkg::ST_RUN;
          end
        end
      end
      hufdec_pkg::ST_RUN: begin
        if (sts.bits_zero) begin
          state_nxt = sts.pend_ok ? hufdec_pkg::ST_FLUSH : hufdec_pkg::ST_IDLE;
        end else if (!sts.cur_ok) begin
          cmd.rd_cur = 1'b1;
          state_nxt  = hufdec_pkg::ST_WAIT_CUR;
        end else begin
          cmd.rd_child = 1'b1;
          state_nxt    = hufdec_pkg::ST_CHECK;
        end
      end
      hufdec_pkg::ST_WAIT_CUR: begin
        cmd.take_cur = 1'b1;
        state_nxt    = hufdec_pkg::ST_RUN;
      end
      hufdec_pkg::ST_CHECK: begin
        // a new symbol pushes out the held one, which needs a free output
        if (!(sts.is_leaf && sts.pend_ok && !sts.out_free)) begin
          cmd.step  = 1'b1;
          state_nxt = hufdec_pkg::ST_RUN;
        end
      end
      hufdec_pkg::ST_FLUSH: begin
        if (sts.out_free) begin
          cmd.push_last = 1'b1;
          state_nxt     = hufdec_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = hufdec_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> hw/rtl/hufdec_dp.sv
module hufdec_dp (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic [hufdec_pkg::IN_DATA_W-1:0]       in_tdata,
  input  hufdec_pkg::cmd_t                       cmd,
  output hufdec_pkg::sts_t                       sts,
  input  logic                                   root_wr,
  input  logic [hufdec_pkg::IDX_W-1:0]           root_wdata,
  output logic [hufdec_pkg::IDX_W-1:0]           root_value,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [hufdec_pkg::SYM_W-1:0]           out_tdata,
  output logic                                   out_tlast
);

  localparam int unsigned IW = hufdec_pkg::IDX_W;
  localparam int unsigned SW = hufdec_pkg::SYM_W;
  localparam int unsigned NW = hufdec_pkg::NBITS_W;

  // input fields
  logic [IW-1:0] f_node_index;
  logic [IW-1:0] f_left;
  logic [IW-1:0] f_right;
  logic          f_leaf;
  logic [SW-1:0] f_sym;
  logic [7:0]    f_code_byte;
  logic [NW-1:0] f_valid_bits;

  assign f_node_index = in_tdata[8:0];
  assign f_left       = in_tdata[17:9];
  assign f_right      = in_tdata[26:18];
  assign f_leaf       = in_tdata[27];
  assign f_sym        = in_tdata[35:28];
  assign f_code_byte  = in_tdata[43:36];
  assign f_valid_bits = in_tdata[47:44];

  hufdec_pkg::node_t node_mem_r [hufdec_pkg::MAX_NODES];
  hufdec_pkg::node_t node_q_r;
  hufdec_pkg::node_t cur_ent_r, cur_ent_nxt;
  hufdec_pkg::node_t wr_ent;

  logic [IW-1:0] root_r, root_nxt;
  logic [IW-1:0] walk_r, walk_nxt;
  logic [IW-1:0] next_r, next_nxt;
  logic          cur_ok_r, cur_ok_nxt;
  logic [7:0]    byte_r, byte_nxt;
  logic [NW-1:0] bits_r, bits_nxt;
  logic [SW-1:0] pend_sym_r, pend_sym_nxt;
  logic          pend_ok_r, pend_ok_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [SW-1:0] out_sym_r, out_sym_nxt;
  logic          out_last_r, out_last_nxt;
  logic [IW-1:0] child;
  logic [IW-1:0] rd_addr;
  logic          rd_en;
  logic          push;

  assign wr_ent  = '{left: f_left, right: f_right, leaf: f_leaf, symbol: f_sym};
  assign child   = byte_r[7] ? cur_ent_r.right : cur_ent_r.left;
  assign rd_en   = cmd.rd_cur || cmd.rd_child;
  assign rd_addr = cmd.rd_cur ? walk_r : child;

  // node table, one write and one registered read
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      node_mem_r[f_node_index] <= wr_ent;
    end
    if (rd_en) begin
      node_q_r <= node_mem_r[rd_addr];
    end
  end

  // walk and output update
  always_comb begin
    root_nxt     = root_wr ? root_wdata : root_r;
    walk_nxt     = walk_r;
    next_nxt     = next_r;
    cur_ent_nxt  = cur_ent_r;
    cur_ok_nxt   = cur_ok_r;
    byte_nxt     = byte_r;
    bits_nxt     = bits_r;
    pend_sym_nxt = pend_sym_r;
    pend_ok_nxt  = pend_ok_r;
    out_sym_nxt  = out_sym_r;
    out_last_nxt = out_last_r;
    push         = 1'b0;

    // a load may change the entry at the walk position
    if (cmd.load) begin
      cur_ok_nxt = 1'b0;
    end
    if (cmd.start) begin
      byte_nxt = f_code_byte;
      bits_nxt = (f_valid_bits > NW'(hufdec_pkg::BYTE_BITS)) ?
                 NW'(hufdec_pkg::BYTE_BITS) : f_valid_bits;
    end
    if (cmd.rd_child) begin
      next_nxt = child;
    end
    if (cmd.take_cur) begin
      cur_ent_nxt = node_q_r;
      cur_ok_nxt  = 1'b1;
    end
    if (cmd.step) begin
      byte_nxt = {byte_r[6:0], 1'b0};
      bits_nxt = bits_r - NW'(1);
      if (node_q_r.leaf) begin
        if (pend_ok_r) begin
          push         = 1'b1;
          out_sym_nxt  = pend_sym_r;
          out_last_nxt = 1'b0;
        end
        pend_sym_nxt = node_q_r.symbol;
        pend_ok_nxt  = 1'b1;
        walk_nxt     = root_r;
        cur_ok_nxt   = 1'b0;
      end else begin
        walk_nxt    = next_r;
        cur_ent_nxt = node_q_r;
        cur_ok_nxt  = 1'b1;
      end
    end
    if (cmd.push_last) begin
      push         = 1'b1;
      out_sym_nxt  = pend_sym_r;
      out_last_nxt = 1'b1;
      pend_ok_nxt  = 1'b0;
    end

    // output register
    if (push) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r      <= '0;
      walk_r      <= '0;
      cur_ok_r    <= 1'b0;
      bits_r      <= '0;
      pend_ok_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      root_r      <= root_nxt;
      walk_r      <= walk_nxt;
      cur_ok_r    <= cur_ok_nxt;
      bits_r      <= bits_nxt;
      pend_ok_r   <= pend_ok_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    next_r     <= next_nxt;
    cur_ent_r  <= cur_ent_nxt;
    byte_r     <= byte_nxt;
    pend_sym_r <= pend_sym_nxt;
    out_sym_r  <= out_sym_nxt;
    out_last_r <= out_last_nxt;
  end

  assign sts.bits_zero = (bits_r == '0);
  assign sts.cur_ok    = cur_ok_r;
  assign sts.pend_ok   = pend_ok_r;
  assign sts.out_free  = !out_valid_r || out_tready;
  assign sts.is_leaf   = node_q_r.leaf;

  assign root_value = root_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_sym_r;
  assign out_tlast  = out_last_r;

endmodule

>>> hw/rtl/huffman_tree_bit_decoder.sv
// Huffman decoder that walks a code tree held in a 512-entry node table.
// A load item (in_tuser = 0) writes one node entry and leaves the block idle. A decode
// item (in_tuser = 1) consumes the leading valid bits of a byte, MSB first,
// emitting one transfer per symbol with tlast on the last symbol of that byte;
// the walk position carries over between bytes, and root_node takes effect at
// the next return to the root. The byte is taken first; each bit is then a dependent
// read of the node table with registered read data: when the current node entry is
// already held, a bit reads the chosen child and then checks it; when it must be
// fetched first (after a symbol, a load or reset), the entry at the walk position
// is read and taken before that. Last, the held final symbol is delivered with
// tlast; output stalls hold the walk, and no new item is taken until the byte is done.
module huffman_tree_bit_decoder (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // config
  input  logic                                  cfg_psel,
  input  logic                                  cfg_penable,
  input  logic                                  cfg_pwrite,
  input  logic [hufdec_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [31:0]                           cfg_pwdata,
  output logic [31:0]                           cfg_prdata,
  output logic                                  cfg_pready,
  // input stream
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // node_index[8:0], left_index[17:9], right_index[26:18], node_is_leaf[27],
  // leaf_symbol[35:28], code_byte[43:36], valid_bits[47:44]
  input  logic [hufdec_pkg::IN_DATA_W-1:0]      in_tdata,
  // func[0]
  input  logic                                  in_tuser,
  // result stream
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // symbol[7:0]
  output logic [hufdec_pkg::SYM_W-1:0]          out_tdata,
  output logic                                  out_tlast
);

  hufdec_pkg::cmd_t              cmd;
  hufdec_pkg::sts_t              sts;
  logic                          root_wr;
  logic [hufdec_pkg::IDX_W-1:0]  root_value;
  logic                          reg_sel;

  // register decode, root_node at byte address 0
  assign cfg_pready = 1'b1;
  assign reg_sel    = (cfg_paddr[hufdec_pkg::CFG_ADDR_W-1] == 1'b0);
  assign root_wr    = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && reg_sel;
  assign cfg_prdata = reg_sel ? {(32 - hufdec_pkg::IDX_W)'(0), root_value} : 32'd0;

  hufdec_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  hufdec_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .root_wr    (root_wr),
    .root_wdata (cfg_pwdata[hufdec_pkg::IDX_W-1:0]),
    .root_value (root_value),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

>>> hw/rtl/hufdec_chk.sv
module hufdec_chk (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_tvalid,
  input logic                                  in_tready,
  input logic                                  in_tuser,
  input logic                                  out_tvalid,
  input logic                                  out_tready,
  input logic [hufdec_pkg::SYM_W-1:0]          out_tdata,
  input logic                                  out_tlast
);

  // a decode transfer keeps the block busy for at least the next cycle
  a_decode_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == hufdec_pkg::FUNC_DECODE) |=> !in_tready)
    else $error("input taken right after a decode item");

  // a node load keeps the block ready for input in the next cycle
  a_load_single: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == hufdec_pkg::FUNC_LOAD) |=> in_tready)
    else $error("node load did not return to idle");

  // new symbols appear only while a byte is being worked on
  a_sym_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("symbol appeared while idle");

  // a stalled result holds its valid and payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tlast)))
    else $error("stalled result changed");

endmodule

bind huffman_tree_bit_decoder hufdec_chk u_hufdec_chk (.*);
